// File: hw/rtl/hamming_block_decoder_assert.svh
// ------------------------------------------------------------------------
// hamming block decoder assertion macros
// shorthand for clocked implications on clk with rst_n low as disable
// ------------------------------------------------------------------------
`ifndef HAMMING_BLOCK_DECODER_ASSERT_SVH
`define HAMMING_BLOCK_DECODER_ASSERT_SVH

// same-cycle implication
`define HBD_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("hamming block decoder check failed");

// next-cycle implication
`define HBD_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("hamming block decoder check failed");

`endif

// File: hw/rtl/hbd_pkg.sv
// ------------------------------------------------------------------------
// hbd_pkg
// shared constants, stage payload types and bit-map helpers
// ------------------------------------------------------------------------
package hbd_pkg;

    localparam int MAX_CODE_BITS = 64;
    localparam int LEN_W         = 7;
    localparam int PC_W          = 3;
    localparam int SYN_W         = 7;
    localparam int BYTE_BITS     = 8;
    localparam int VB_W          = 4;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PARITY_COUNT = 1'b1;

    localparam logic [LEN_W-1:0] CODE_LENGTH_RST  = 7'd7;
    localparam logic [PC_W-1:0]  PARITY_COUNT_RST = 3'd3;

    // number of power-of-two positions not above n
    function automatic int count_pow2(int n);
        int c;
        c = 0;
        for (int p = 1; p <= n; p = p * 2)
        begin
            c++;
        end
        return c;
    endfunction

    localparam int DATA_BITS = MAX_CODE_BITS - count_pow2(MAX_CODE_BITS);
    // hold word of the byte slicer, never narrower than one byte
    localparam int HOLD_BITS = (DATA_BITS < BYTE_BITS) ? BYTE_BITS : DATA_BITS;
    localparam int NB_W      = $clog2(HOLD_BITS + 1);

    // 1-based codeword position of data bit i
    function automatic int data_pos(int i);
        int k;
        int res;
        k   = 0;
        res = 0;
        for (int p = 1; p <= MAX_CODE_BITS; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                if (k == i)
                    res = p;
                k++;
            end
        end
        return res;
    endfunction

    // bits of the codeword whose position number has bit j set
    function automatic logic [MAX_CODE_BITS-1:0] pos_bit_mask(int j);
        logic [MAX_CODE_BITS-1:0] m;
        m = '0;
        for (int k = 0; k < MAX_CODE_BITS; k++)
        begin
            m[k] = (((k + 1) >> j) & 1) != 0;
        end
        return m;
    endfunction

    typedef struct packed {
        logic [MAX_CODE_BITS-1:0] cw;
        logic [SYN_W-1:0]         synd;
        logic [LEN_W-1:0]         len;
    } hbd_s1_t;

    typedef struct packed {
        logic [HOLD_BITS-1:0] data;
        logic [NB_W-1:0]      nbits;
        logic                 corrected;
        logic [SYN_W-1:0]     synd;
        logic                 unc;
    } hbd_s2_t;

endpackage

// File: hw/rtl/hbd_syndrome.sv
// ------------------------------------------------------------------------
// hbd_syndrome
// stage one: length mask and syndrome parity trees
// ------------------------------------------------------------------------
module hbd_syndrome
    import hbd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [LEN_W-1:0]         code_length,
    input  logic [PC_W-1:0]          parity_count,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [MAX_CODE_BITS-1:0] in_cw,
    output logic                     out_valid,
    input  logic                     out_ready,
    output hbd_s1_t                  out_data
);

    logic                     s1_valid_reg;
    hbd_s1_t                  s1_reg;
    hbd_s1_t                  s1_next;
    logic [LEN_W-1:0]         len;
    logic [MAX_CODE_BITS-1:0] len_mask;
    logic [SYN_W-1:0]         synd_raw;
    logic [SYN_W-1:0]         synd_mask;

    always_comb
    begin
        len = (code_length > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS) : code_length;
        for (int k = 0; k < MAX_CODE_BITS; k++)
        begin
            len_mask[k] = LEN_W'(k) < len;
        end
        s1_next.cw  = in_cw & len_mask;
        s1_next.len = len;
        for (int j = 0; j < SYN_W; j++)
        begin
            synd_raw[j]  = ^(s1_next.cw & pos_bit_mask(j));
            synd_mask[j] = PC_W'(j) < parity_count;
        end
        s1_next.synd = synd_raw & synd_mask;
    end

    assign in_ready  = !s1_valid_reg || out_ready;
    assign out_valid = s1_valid_reg;
    assign out_data  = s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_reg <= s1_next;
    end

endmodule

// File: hw/rtl/hbd_correct.sv
// ------------------------------------------------------------------------
// hbd_correct
// stage two: range check, single bit flip and data bit gathering
// ------------------------------------------------------------------------
module hbd_correct
    import hbd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  hbd_s1_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output hbd_s2_t out_data
);

    logic                     s2_valid_reg;
    hbd_s2_t                  s2_reg;
    hbd_s2_t                  s2_next;
    logic                     unc;
    logic [MAX_CODE_BITS-1:0] flip;
    logic [MAX_CODE_BITS-1:0] cw_fixed;
    logic [DATA_BITS-1:0]     data_raw;
    logic [LEN_W-1:0]         npow;

    genvar gi;
    generate
        for (gi = 0; gi < DATA_BITS; gi++)
        begin : g_gather
            localparam int P = data_pos(gi);
            assign data_raw[gi] = cw_fixed[P-1];
        end
    endgenerate

    always_comb
    begin
        unc = in_data.synd > in_data.len;
        for (int k = 0; k < MAX_CODE_BITS; k++)
        begin
            flip[k] = !unc && (in_data.synd == SYN_W'(k + 1));
        end
        cw_fixed = in_data.cw ^ flip;
        npow     = '0;
        for (int j = 0; j < SYN_W; j++)
        begin
            if (in_data.len >= LEN_W'(1 << j))
                npow = npow + LEN_W'(1);
        end
        s2_next.unc       = unc;
        s2_next.synd      = in_data.synd;
        s2_next.corrected = !unc && (in_data.synd != '0);
        s2_next.data      = unc ? '0 : HOLD_BITS'(data_raw);
        s2_next.nbits     = unc ? '0 : NB_W'(in_data.len - npow);
    end

    assign in_ready  = !s2_valid_reg || out_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (in_ready)
            s2_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s2_reg <= s2_next;
    end

endmodule

// File: hw/rtl/hbd_serialiser.sv
// ------------------------------------------------------------------------
// hbd_serialiser
// stage three: byte slicer with output register
// ------------------------------------------------------------------------
module hbd_serialiser
    import hbd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hbd_s2_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       out_byte,
    output logic [VB_W-1:0]  out_vb,
    output logic             out_corr,
    output logic [SYN_W-1:0] out_pos,
    output logic             out_unc,
    output logic             out_last
);

    logic             sr_valid_reg;
    hbd_s2_t          sr_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic [VB_W-1:0]  out_vb_reg;
    logic             out_corr_reg;
    logic [SYN_W-1:0] out_pos_reg;
    logic             out_unc_reg;
    logic             out_last_reg;
    logic             out_free;
    logic             sr_fire;
    logic             sr_last;
    logic [VB_W-1:0]  sr_vb;

    assign out_free = !out_valid_reg || out_ready;
    assign sr_fire  = sr_valid_reg && out_free;
    assign sr_last  = sr_reg.nbits <= NB_W'(BYTE_BITS);
    assign sr_vb    = sr_last ? VB_W'(sr_reg.nbits) : VB_W'(BYTE_BITS);
    assign in_ready = !sr_valid_reg || (sr_fire && sr_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sr_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                sr_valid_reg <= in_valid;
            if (out_free)
                out_valid_reg <= sr_valid_reg;
        end
    end

    // hold word: load a new item or move on to its next byte
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            sr_reg <= in_data;
        else if (sr_fire && !sr_last)
        begin
            sr_reg.data  <= sr_reg.data >> BYTE_BITS;
            sr_reg.nbits <= sr_reg.nbits - NB_W'(BYTE_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (sr_fire)
        begin
            out_byte_reg <= sr_reg.data[7:0];
            out_vb_reg   <= sr_vb;
            out_corr_reg <= sr_reg.corrected;
            out_pos_reg  <= sr_reg.synd;
            out_unc_reg  <= sr_reg.unc;
            out_last_reg <= sr_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_vb    = out_vb_reg;
    assign out_corr  = out_corr_reg;
    assign out_pos   = out_pos_reg;
    assign out_unc   = out_unc_reg;
    assign out_last  = out_last_reg;

endmodule

// File: hw/rtl/hamming_block_decoder.sv
// path: a codeword passes three register stages plus the output register before its first
//   result item shows on the master side
// pacing: the byte slicer in the last stage takes a new codeword only as the last byte of
//   the one it holds moves out, so it sets the codeword rate
// reset: rst_n low clears all stage valid bits, code_length to 7, parity_count to 3
// ------------------------------------------------------------------------
// hamming_block_decoder
// single error correcting hamming decoder, codeword in, data bytes out
// ------------------------------------------------------------------------
module hamming_block_decoder
    import hbd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write port
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // codeword items
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [MAX_CODE_BITS-1:0] s_axis_tdata,  // [63:0] codeword
    // result items
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [23:0]              m_axis_tdata,  // [7:0] data_byte, [11:8] valid_bits,
                                                    // [18:12] error_position, [23:19] zero
    output logic [1:0]               m_axis_tuser,  // [0] corrected, [1] uncorrectable
    output logic                     m_axis_tlast   // last byte of the codeword
);

    localparam int TDATA_PAD = 24 - 8 - VB_W - SYN_W;

    // configuration registers, written only while pipeline is empty: user's rule, unenforced
    logic [LEN_W-1:0] code_length_reg;
    logic [PC_W-1:0]  parity_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg  <= CODE_LENGTH_RST;
            parity_count_reg <= PARITY_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CODE_LENGTH:  code_length_reg  <= cfg_data[LEN_W-1:0];
                REG_PARITY_COUNT: parity_count_reg <= cfg_data[PC_W-1:0];
                default:          ;
            endcase
        end
    end

    // stage links
    logic             s1_valid;
    logic             s1_ready;
    hbd_s1_t          s1_data;
    logic             s2_valid;
    logic             s2_ready;
    hbd_s2_t          s2_data;
    logic [7:0]       res_byte;
    logic [VB_W-1:0]  res_vb;
    logic             res_corr;
    logic [SYN_W-1:0] res_pos;
    logic             res_unc;

    // stage one: mask by length, syndrome from position parity trees
    hbd_syndrome u_syndrome (
        .clk          (clk),
        .rst_n        (rst_n),
        .code_length  (code_length_reg),
        .parity_count (parity_count_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_cw        (s_axis_tdata),
        .out_valid    (s1_valid),
        .out_ready    (s1_ready),
        .out_data     (s1_data)
    );

    // stage two: flip the named position, gather data bits in order
    hbd_correct u_correct (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // stage three: one byte per cycle into the output register whenever that register is free
    hbd_serialiser u_serialiser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (res_byte),
        .out_vb    (res_vb),
        .out_corr  (res_corr),
        .out_pos   (res_pos),
        .out_unc   (res_unc),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{TDATA_PAD{1'b0}}, res_pos, res_vb, res_byte};
    assign m_axis_tuser = {res_unc, res_corr};

endmodule

// File: hw/rtl/hbd_checker.sv
// ------------------------------------------------------------------------
// hbd_checker
// port-level checks on the result channel of the decoder
// ------------------------------------------------------------------------
`include "hamming_block_decoder_assert.svh"

module hbd_checker
    import hbd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    logic             res_stalled;
    logic [26:0]      res_word;
    logic             res_empty;
    logic [SYN_W-1:0] res_pos;
    logic [VB_W-1:0]  res_vb;
    logic             res_corr;
    logic             res_unc;

    assign res_stalled = m_axis_tvalid && !m_axis_tready;
    assign res_word    = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
    assign res_empty   = m_axis_tdata[11:0] == 12'd0;
    assign res_pos     = m_axis_tdata[18:12];
    assign res_vb      = m_axis_tdata[11:8];
    assign res_corr    = m_axis_tuser[0];
    assign res_unc     = m_axis_tuser[1];

    // stalled result item holds
    `HBD_ASSERT_NXT(a_stall_hold, res_stalled, m_axis_tvalid && $stable(res_word))

    // uncorrectable item is a single empty closing item
    `HBD_ASSERT_IMP(a_unc_empty, m_axis_tvalid && res_unc, m_axis_tlast && res_empty && !res_corr)

    // bytes before the last are full
    `HBD_ASSERT_IMP(a_full_bytes, m_axis_tvalid && !m_axis_tlast, res_vb == 4'd8)

    // corrected flag agrees with the reported position
    `HBD_ASSERT_IMP(a_corr_pos, m_axis_tvalid, res_corr == ((res_pos != 7'd0) && !res_unc))

endmodule

bind hamming_block_decoder hbd_checker u_hbd_checker (.*);
